/* hw/rtl/vasl_pkg.sv */
// shared types, constants and widths for the velocity average / steering limit block
// no dependencies; imported by every module of the block
package vasl_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int COUNT_WIDTH     = 16;
    localparam int SUM_WIDTH       = 32;
    localparam int CFG_WIDTH       = 10;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int FRAC_BITS       = 8;
    localparam int STEP_WIDTH      = $clog2(SUM_WIDTH);

    localparam logic [STEP_WIDTH-1:0] STEP_LAST = STEP_WIDTH'(SUM_WIDTH - 1);

    // item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CUT_SLOPE  = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STEER_GAIN = CFG_INDEX_WIDTH'(1);

    localparam logic [CFG_WIDTH-1:0] CUT_SLOPE_RESET  = CFG_WIDTH'(256);
    localparam logic [CFG_WIDTH-1:0] STEER_GAIN_RESET = CFG_WIDTH'(269);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    localparam sample_t SAMPLE_MAX = sample_t'((2 ** (SAMPLE_WIDTH - 1)) - 1);
    localparam sample_t SAMPLE_MIN = sample_t'(-(2 ** (SAMPLE_WIDTH - 1)));

    typedef struct packed {
        logic    kind;
        sample_t vel_x;
        sample_t vel_y;
    } in_item_t;

    typedef struct packed {
        sample_t cmd_x;
        sample_t cmd_y;
        logic    held;
        logic    dropped;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic acc;    // accumulate a sample
        logic start;  // latch sums into the divider, clear accumulators
        logic step;   // one restoring divide step on both lanes
        logic sat;    // saturate quotients
        logic emit;   // steering cut, update last command, load output register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_blocked;
    } ctrl_stat_t;

endpackage

/* hw/rtl/vasl_ctrl.sv */
// controller state machine for the velocity average / steering limit block
// depends on vasl_pkg; drives vasl_dp through ctrl_cmd_t
module vasl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_kind,
    output logic                item_ready,
    input  vasl_pkg::ctrl_stat_t stat,
    output vasl_pkg::ctrl_cmd_t  cmd
);
    import vasl_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SAT  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [STEP_WIDTH-1:0] step_reg;
    logic [STEP_WIDTH-1:0] step_next;

    assign item_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd.acc   = 1'b0;
        cmd.start = 1'b0;
        cmd.step  = 1'b0;
        cmd.sat   = 1'b0;
        cmd.emit  = 1'b0;
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (item_kind == KIND_TICK)
                    begin
                        cmd.start  = 1'b1;
                        step_next  = '0;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        cmd.acc = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.step  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                cmd.sat    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!stat.out_blocked)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

/* hw/rtl/vasl_dp.sv */
// datapath: accumulators, two-lane restoring divider, steering cut, output register
// depends on vasl_pkg; sequenced by vasl_ctrl
module vasl_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  vasl_pkg::ctrl_cmd_t                  cmd,
    output vasl_pkg::ctrl_stat_t                 stat,
    input  vasl_pkg::in_item_t                   sample,
    input  logic                                 cfg_valid,
    input  logic [vasl_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [vasl_pkg::CFG_WIDTH-1:0]       cfg_data,
    output logic                                 cmd_valid,
    input  logic                                 cmd_ready,
    output vasl_pkg::out_item_t                  cmd_item
);
    import vasl_pkg::*;

    localparam int PROD_WIDTH = SAMPLE_WIDTH + CFG_WIDTH;
    localparam int GAIN_WIDTH = SAMPLE_WIDTH + 1 + CFG_WIDTH;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] rem;
        logic [SUM_WIDTH-1:0]   quo;
    } div_lane_t;

    function automatic div_lane_t div_step(input div_lane_t lane,
                                           input logic [COUNT_WIDTH-1:0] den);
        logic [COUNT_WIDTH:0] shifted;
        logic                 fits;
        div_lane_t            res;
        shifted = {lane.rem, lane.quo[SUM_WIDTH-1]};
        fits    = (shifted >= {1'b0, den});
        res.rem = fits ? COUNT_WIDTH'(shifted - {1'b0, den}) : shifted[COUNT_WIDTH-1:0];
        res.quo = {lane.quo[SUM_WIDTH-2:0], fits};
        return res;
    endfunction

    // signed quotient from magnitude and sign, clamped to the sample range
    function automatic sample_t sat_quot(input logic [SUM_WIDTH-1:0] q, input logic neg);
        logic [SUM_WIDTH-1:0] pos_lim;
        sample_t              res;
        pos_lim = SUM_WIDTH'(SAMPLE_MAX);
        if (neg)
        begin
            if (q > pos_lim + 1'b1)
                res = SAMPLE_MIN;
            else
                res = sample_t'(SAMPLE_WIDTH'(SUM_WIDTH'(0) - q));
        end
        else
        begin
            if (q > pos_lim)
                res = SAMPLE_MAX;
            else
                res = sample_t'(q[SAMPLE_WIDTH-1:0]);
        end
        return res;
    endfunction

    logic [CFG_WIDTH-1:0]         cut_slope_reg;
    logic [CFG_WIDTH-1:0]         steer_gain_reg;
    logic signed [SUM_WIDTH-1:0]  sum_x_reg;
    logic signed [SUM_WIDTH-1:0]  sum_y_reg;
    logic [COUNT_WIDTH-1:0]       count_reg;
    logic                         overflow_reg;
    sample_t                      last_x_reg;
    sample_t                      last_y_reg;

    div_lane_t                    lane_x_reg;
    div_lane_t                    lane_y_reg;
    logic [COUNT_WIDTH-1:0]       den_reg;
    logic                         neg_x_reg;
    logic                         neg_y_reg;
    logic                         empty_reg;
    logic                         dropped_reg;

    sample_t                      avg_x_reg;
    sample_t                      avg_y_reg;
    logic [SAMPLE_WIDTH:0]        ay_reg;

    out_item_t                    out_reg;
    logic                         out_valid_reg;

    logic                         sample_nz;
    logic                         count_full;
    logic [SUM_WIDTH-1:0]         mag_x;
    logic [SUM_WIDTH-1:0]         mag_y;
    sample_t                      sat_x;
    sample_t                      sat_y;
    logic                         vec_nz;
    logic                         x_nonpos;
    logic [PROD_WIDTH-1:0]        cut_lhs;
    logic [PROD_WIDTH-1:0]        cut_rhs;
    logic [GAIN_WIDTH-1:0]        gain_prod;
    logic [GAIN_WIDTH-1:0]        gain_shr;
    sample_t                      cut_x;
    sample_t                      fin_x;
    logic                         fin_nz;

    assign sample_nz  = (sample.vel_x != '0) || (sample.vel_y != '0);
    assign count_full = &count_reg;

    assign mag_x = sum_x_reg[SUM_WIDTH-1] ? SUM_WIDTH'(-sum_x_reg) : SUM_WIDTH'(sum_x_reg);
    assign mag_y = sum_y_reg[SUM_WIDTH-1] ? SUM_WIDTH'(-sum_y_reg) : SUM_WIDTH'(sum_y_reg);

    assign sat_x = empty_reg ? sample_t'(0) : sat_quot(lane_x_reg.quo, neg_x_reg);
    assign sat_y = empty_reg ? sample_t'(0) : sat_quot(lane_y_reg.quo, neg_y_reg);

    // steering cut on the averaged vector
    assign vec_nz    = (avg_x_reg != '0) || (avg_y_reg != '0);
    assign x_nonpos  = (avg_x_reg <= sample_t'(0));
    assign cut_lhs   = PROD_WIDTH'({ay_reg, FRAC_BITS'(0)});
    assign cut_rhs   = PROD_WIDTH'(cut_slope_reg) * PROD_WIDTH'(avg_x_reg[SAMPLE_WIDTH-2:0]);
    assign gain_prod = GAIN_WIDTH'(ay_reg) * GAIN_WIDTH'(steer_gain_reg);
    assign gain_shr  = gain_prod >> FRAC_BITS;
    assign cut_x     = (gain_shr > GAIN_WIDTH'(SAMPLE_MAX)) ? SAMPLE_MAX
                                                           : sample_t'(gain_shr[SAMPLE_WIDTH-1:0]);
    assign fin_x     = (vec_nz && (x_nonpos || (cut_lhs > cut_rhs))) ? cut_x : avg_x_reg;
    assign fin_nz    = (fin_x != '0) || (avg_y_reg != '0);

    assign stat.out_blocked = out_valid_reg && !cmd_ready;
    assign cmd_valid        = out_valid_reg;
    assign cmd_item         = out_reg;

    // control-side state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut_slope_reg  <= CUT_SLOPE_RESET;
            steer_gain_reg <= STEER_GAIN_RESET;
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == REG_CUT_SLOPE)
                    cut_slope_reg <= cfg_data;
                else if (cfg_index == REG_STEER_GAIN)
                    steer_gain_reg <= cfg_data;
            end

            if (cmd.acc && sample_nz)
            begin
                if (count_full)
                begin
                    overflow_reg <= 1'b1;
                end
                else
                begin
                    sum_x_reg <= sum_x_reg + SUM_WIDTH'(sample.vel_x);
                    sum_y_reg <= sum_y_reg + SUM_WIDTH'(sample.vel_y);
                    count_reg <= count_reg + 1'b1;
                end
            end
            else if (cmd.start)
            begin
                sum_x_reg    <= '0;
                sum_y_reg    <= '0;
                count_reg    <= '0;
                overflow_reg <= 1'b0;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                if (fin_nz)
                begin
                    last_x_reg <= fin_x;
                    last_y_reg <= avg_y_reg;
                end
            end
            else if (cmd_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            lane_x_reg  <= '{rem: '0, quo: mag_x};
            lane_y_reg  <= '{rem: '0, quo: mag_y};
            den_reg     <= count_reg;
            neg_x_reg   <= sum_x_reg[SUM_WIDTH-1];
            neg_y_reg   <= sum_y_reg[SUM_WIDTH-1];
            empty_reg   <= (count_reg == '0);
            dropped_reg <= overflow_reg;
        end
        else if (cmd.step)
        begin
            lane_x_reg <= div_step(lane_x_reg, den_reg);
            lane_y_reg <= div_step(lane_y_reg, den_reg);
        end

        if (cmd.sat)
        begin
            avg_x_reg <= sat_x;
            avg_y_reg <= sat_y;
            ay_reg    <= sat_y[SAMPLE_WIDTH-1] ? (SAMPLE_WIDTH + 1)'(-(SAMPLE_WIDTH + 1)'(sat_y))
                                               : (SAMPLE_WIDTH + 1)'(sat_y);
        end

        if (cmd.emit)
        begin
            out_reg.cmd_x   <= fin_nz ? fin_x : last_x_reg;
            out_reg.cmd_y   <= fin_nz ? avg_y_reg : last_y_reg;
            out_reg.held    <= !fin_nz;
            out_reg.dropped <= dropped_reg;
        end
    end

endmodule

/* hw/rtl/velocity_average_steer_limit_core.sv */
// top level of the velocity average / steering limit block
// depends on vasl_pkg, vasl_ctrl and vasl_dp
//
// velocity samples (signed q7.8 x/y pairs) are summed between ticks; an all-zero
// pair is ignored and once the 16-bit count is full further samples are dropped
// and reported with the next command. a tick divides both sums by the count
// (truncating toward zero, zero for an empty period), applies the steering cut
// (outside the cut_slope cone, x becomes |y| * steer_gain, saturated) and emits
// one command item; a zero command repeats the last nonzero one with held set.
// a sample item is taken while the block is idle, and the block stays ready for
// the next one. a tick item occupies the block while it latches the sums, runs
// the shared two-lane restoring divider one quotient bit per step, saturates,
// and does the cut and the load of the output register, which waits while a
// previous command item is still unclaimed. the output register lets the next
// item in while a command waits.
// configuration writes are always taken; write only while no tick is in flight.
module velocity_average_steer_limit_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input items
    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    input  vasl_pkg::in_item_t                   sample,
    // command items
    output logic                                 cmd_valid,
    input  logic                                 cmd_ready,
    output vasl_pkg::out_item_t                  cmd,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [vasl_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [vasl_pkg::CFG_WIDTH-1:0]       cfg_data
);
    import vasl_pkg::*;

    ctrl_cmd_t  ctrl_cmd;
    ctrl_stat_t ctrl_stat;

    // a register is written whenever cfg_valid is seen with its index, no back-pressure
    assign cfg_ready = 1'b1;

    // sequencing: idle / divide / saturate / emit
    vasl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (sample_valid),
        .item_kind  (sample.kind),
        .item_ready (sample_ready),
        .stat       (ctrl_stat),
        .cmd        (ctrl_cmd)
    );

    // accumulators, divider, cut logic and output register
    vasl_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ctrl_cmd),
        .stat      (ctrl_stat),
        .sample    (sample),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd)
    );

endmodule
